@@ rtl/iirtf_pkg.sv @@
// Shared types and constants for the fifth-order torque filter.
package iirtf_pkg;

  localparam int ORDER          = 5;
  localparam int COEF_FRAC_BITS = 24;
  localparam int NUM_COEFS      = 2 * ORDER + 1;
  localparam int TAP_W          = $clog2(NUM_COEFS);
  localparam int HIST_IDX_W     = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int PROD_W         = 64;
  localparam int ACC_W          = PROD_W + $clog2(NUM_COEFS + 1);
  localparam int SHIFT_W        = ACC_W - COEF_FRAC_BITS;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_FILTER = 1'b1;

  typedef struct packed {
    logic               func;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] sample;
    logic               restart;
  } req_item_t;

  typedef struct packed {
    logic signed [31:0] torque;
    logic               saturated;
  } rsp_item_t;

endpackage

@@ rtl/iir_order5_torque_filter.sv @@
// Fifth-order direct form I IIR torque filter built on one shared multiply-accumulate unit.
// A filter item runs its 11 taps through the single 32x32 multiplier, then a drain step and
// a rounding step; the rounding step waits while a result stalls.
// No new item is taken until a filter item has finished; a load item is written in the idle
// state, and the block stays idle.
// Reset clears the coefficient table, both histories, the sequencer and the result valid flag.
module iir_order5_torque_filter
  import iirtf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MAC   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_ROUND = 2'd3;

  logic [1:0]                state;
  logic [TAP_W-1:0]          tap;
  logic signed [31:0]        coef_table [NUM_COEFS];
  logic signed [31:0]        x_hist [ORDER];
  logic signed [31:0]        y_hist [ORDER];
  logic signed [31:0]        x_cur;
  logic signed [PROD_W-1:0]  prod;
  logic                      prod_sub;
  logic                      prod_valid;
  logic signed [ACC_W-1:0]   acc;

  logic                      req_take;
  logic                      rsp_free;
  logic [HIST_IDX_W-1:0]     hist_idx;
  logic signed [31:0]        operand;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [SHIFT_W-1:0] shifted;
  logic                      over;
  logic signed [31:0]        y_val;

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    hist_idx = '0;
    operand  = x_cur;
    if (tap == '0) begin
      operand = x_cur;
    end else if (tap <= TAP_W'(ORDER)) begin
      hist_idx = HIST_IDX_W'(tap - TAP_W'(1));
      operand  = x_hist[hist_idx];
    end else begin
      hist_idx = HIST_IDX_W'(tap - TAP_W'(ORDER + 1));
      operand  = y_hist[hist_idx];
    end
  end

  assign prod_ext = ACC_W'(prod);
  assign shifted  = acc[ACC_W-1:COEF_FRAC_BITS];
  assign over     = (shifted[SHIFT_W-1:31] != '0) && (shifted[SHIFT_W-1:31] != '1);

  always_comb begin
    if (!over) begin
      y_val = shifted[31:0];
    end else if (shifted[SHIFT_W-1]) begin
      y_val = 32'sh8000_0000;
    end else begin
      y_val = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tap        <= '0;
      prod_valid <= 1'b0;
      rsp_valid  <= 1'b0;
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef_table[i] <= '0;
      end
      for (int i = 0; i < ORDER; i++) begin
        x_hist[i] <= '0;
        y_hist[i] <= '0;
      end
    end else begin
      if (state == S_ROUND && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_take) begin
            if (req.func == FUNC_LOAD) begin
              if (req.coef_index < 4'(NUM_COEFS)) begin
                coef_table[req.coef_index[TAP_W-1:0]] <= req.coef_value;
              end
            end else begin
              x_cur <= req.sample;
              acc   <= ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
              tap   <= '0;
              state <= S_MAC;
              if (req.restart) begin
                for (int i = 0; i < ORDER; i++) begin
                  x_hist[i] <= '0;
                  y_hist[i] <= '0;
                end
              end
            end
          end
        end
        S_MAC: begin
          prod       <= coef_table[tap] * operand;
          prod_sub   <= (tap > TAP_W'(ORDER));
          prod_valid <= 1'b1;
          if (prod_valid) begin
            acc <= prod_sub ? acc - prod_ext : acc + prod_ext;
          end
          if (tap == TAP_W'(NUM_COEFS - 1)) begin
            state <= S_DRAIN;
          end else begin
            tap <= tap + TAP_W'(1);
          end
        end
        S_DRAIN: begin
          acc        <= prod_sub ? acc - prod_ext : acc + prod_ext;
          prod_valid <= 1'b0;
          state      <= S_ROUND;
        end
        S_ROUND: begin
          if (rsp_free) begin
            rsp.torque    <= y_val;
            rsp.saturated <= over;
            for (int i = ORDER - 1; i > 0; i--) begin
              x_hist[i] <= x_hist[i-1];
              y_hist[i] <= y_hist[i-1];
            end
            x_hist[0] <= x_cur;
            y_hist[0] <= y_val;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/iirtf_checker.sv @@
// Port-level checks for the torque filter, bound to its top level.
module iirtf_checker
  import iirtf_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_stall,
  input req_item_t req,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input rsp_item_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("result item dropped while stalled");

  a_filter_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.func == FUNC_FILTER |=> req_stall)
    else $error("filter item did not occupy the block");

  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.func == FUNC_LOAD |=> !req_stall)
    else $error("load item held the block");

  a_sat_clamp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.saturated |->
      (rsp.torque == 32'sh7fff_ffff) || (rsp.torque == 32'sh8000_0000))
    else $error("saturated result not at a limit");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid && !req_stall)
    else $error("block not empty after reset");

endmodule

bind iir_order5_torque_filter iirtf_checker u_iirtf_checker (.*);
